/* src/wash_cycle_sequencer_defines.svh */
// Assertion shorthands shared by the checkers of the wash cycle sequencer.
// Each expects a clock named clk and a reset named rst in scope.
`ifndef WASH_CYCLE_SEQUENCER_DEFINES_SVH
`define WASH_CYCLE_SEQUENCER_DEFINES_SVH

// Condition holds in the same cycle as the trigger
`define WCS_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("wash cycle sequencer check failed");

// Condition holds in the cycle after the trigger
`define WCS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("wash cycle sequencer check failed");

`endif

/* src/wcs_pkg.sv */
package wcs_pkg;

  // Timer width default
  localparam int TIMER_BITS_DEF = 16;

  // Register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOAK_SPIN    = 3'd0,
    CFG_WASH_SPIN    = 3'd1,
    CFG_WASH_PAUSE   = 3'd2,
    CFG_WASH_ROUNDS  = 3'd3,
    CFG_RINSE_SPIN   = 3'd4,
    CFG_FINAL_SPIN   = 3'd5,
    CFG_REVERSE      = 3'd6
  } cfg_idx_t;

  localparam logic [15:0] SOAK_SPIN_RST   = 16'd2000;
  localparam logic [15:0] WASH_SPIN_RST   = 16'd2400;
  localparam logic [15:0] WASH_PAUSE_RST  = 16'd1000;
  localparam logic [3:0]  WASH_ROUNDS_RST = 4'd3;
  localparam logic [15:0] RINSE_SPIN_RST  = 16'd3000;
  localparam logic [15:0] FINAL_SPIN_RST  = 16'd4000;
  localparam logic [15:0] REVERSE_RST     = 16'd500;

  // Phase codes as shown on the result
  localparam logic [2:0] PHC_STOP  = 3'd0;
  localparam logic [2:0] PHC_SOAK  = 3'd1;
  localparam logic [2:0] PHC_WASH  = 3'd2;
  localparam logic [2:0] PHC_RINSE = 3'd3;
  localparam logic [2:0] PHC_SPIN  = 3'd4;
  localparam logic [2:0] PHC_EMERG = 3'd5;

  // Sub-step codes
  localparam logic [1:0] SUB_FIRST  = 2'd0;
  localparam logic [1:0] SUB_SECOND = 2'd1;
  localparam logic [1:0] SUB_THIRD  = 2'd2;

  // Start choice codes
  localparam logic [1:0] CHOICE_SOAK  = 2'd0;
  localparam logic [1:0] CHOICE_WASH  = 2'd1;
  localparam logic [1:0] CHOICE_RINSE = 2'd2;
  localparam logic [1:0] CHOICE_SPIN  = 2'd3;

  // Main phase state, one-hot
  typedef enum logic [5:0] {
    PH_STOP  = 6'b000001,
    PH_SOAK  = 6'b000010,
    PH_WASH  = 6'b000100,
    PH_RINSE = 6'b001000,
    PH_SPIN  = 6'b010000,
    PH_EMERG = 6'b100000
  } phase_t;

  typedef struct packed {
    logic select_press;
    logic start_press;
    logic tank_full;
    logic tank_empty;
    logic door_open;
  } in_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] selected_first;
    logic       stop_lamp;
    logic       soak_lamp;
    logic       wash_lamp;
    logic       rinse_lamp;
    logic       spin_lamp;
    logic       fill_valve;
    logic       drain_pump;
    logic       motor_right;
    logic       motor_left;
  } out_item_t;

  typedef struct packed {
    logic [15:0] soak_spin_ms;
    logic [15:0] wash_spin_ms;
    logic [15:0] wash_pause_ms;
    logic [3:0]  wash_rounds_minus_one;
    logic [15:0] rinse_spin_ms;
    logic [15:0] final_spin_ms;
    logic [15:0] reverse_period_ms;
  } cfg_t;

  // Control state, timers travel separately
  typedef struct packed {
    phase_t     phase;
    logic [1:0] sub_step;
    logic [1:0] start_choice;
    logic       spin_direction;
    logic [3:0] round_count;
    logic       door_prev;
  } ctl_state_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_STOP:  code = PHC_STOP;
      PH_SOAK:  code = PHC_SOAK;
      PH_WASH:  code = PHC_WASH;
      PH_RINSE: code = PHC_RINSE;
      PH_SPIN:  code = PHC_SPIN;
      PH_EMERG: code = PHC_EMERG;
      default:  code = PHC_STOP;
    endcase
    return code;
  endfunction

endpackage

/* src/wcs_core.sv */
// Next state and result for one tick
module wcs_core import wcs_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  ctl_state_t            st,
  input  logic [TIMER_BITS-1:0] phase_elapsed,
  input  logic [TIMER_BITS-1:0] reverse_elapsed,
  input  cfg_t                  cfg,
  input  in_item_t              item,
  output ctl_state_t            st_next,
  output logic [TIMER_BITS-1:0] phase_elapsed_next,
  output logic [TIMER_BITS-1:0] reverse_elapsed_next,
  output out_item_t             result
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  logic [TIMER_BITS-1:0] pe_inc;
  logic [TIMER_BITS-1:0] re_inc;
  logic                  reverse_now;
  logic [15:0]           agit_len;
  logic                  agit_done;
  logic                  pause_done;
  logic                  spin_done;
  logic                  rising;
  logic                  do_enter;
  logic                  do_stop;
  phase_t                enter_ph;
  logic [1:0]            enter_sub;
  logic                  agitating;

  // Saturating timer increments
  assign pe_inc = (phase_elapsed == TIMER_MAX) ? phase_elapsed : phase_elapsed + 1'b1;
  assign re_inc = (reverse_elapsed == TIMER_MAX) ? reverse_elapsed : reverse_elapsed + 1'b1;

  assign reverse_now = CMP_W'(re_inc) >= CMP_W'(cfg.reverse_period_ms);

  // Agitation length of the current phase
  always_comb begin
    unique case (st.phase)
      PH_SOAK:  agit_len = cfg.soak_spin_ms;
      PH_WASH:  agit_len = cfg.wash_spin_ms;
      default:  agit_len = cfg.rinse_spin_ms;
    endcase
  end

  assign agit_done  = CMP_W'(pe_inc) > CMP_W'(agit_len);
  assign pause_done = CMP_W'(pe_inc) > CMP_W'(cfg.wash_pause_ms);
  assign spin_done  = CMP_W'(pe_inc) > CMP_W'(cfg.final_spin_ms);
  assign rising     = item.door_open && !st.door_prev;

  // Phase transitions
  always_comb begin
    st_next              = st;
    st_next.door_prev    = item.door_open;
    phase_elapsed_next   = phase_elapsed;
    reverse_elapsed_next = reverse_elapsed;
    do_enter             = 1'b0;
    do_stop              = 1'b0;
    enter_ph             = st.phase;
    enter_sub            = SUB_FIRST;
    agitating            = 1'b0;

    if (rising) begin
      do_enter            = 1'b1;
      enter_ph            = PH_EMERG;
      st_next.round_count = '0;
    end else begin
      unique case (st.phase)
        PH_STOP: begin
          if (item.start_press) begin
            st_next.round_count = '0;
            do_enter            = 1'b1;
            unique case (st.start_choice)
              CHOICE_SOAK:  enter_ph = PH_SOAK;
              CHOICE_WASH:  enter_ph = PH_WASH;
              CHOICE_RINSE: enter_ph = PH_RINSE;
              default:      enter_ph = PH_SPIN;
            endcase
          end else if (item.select_press) begin
            st_next.start_choice = st.start_choice + 1'b1;
          end
        end
        PH_SOAK: begin
          if (st.sub_step == SUB_FIRST) begin
            if (item.tank_full) begin
              do_enter  = 1'b1;
              enter_sub = SUB_SECOND;
            end
          end else if (st.sub_step == SUB_SECOND) begin
            agitating = 1'b1;
            if (agit_done) begin
              st_next.round_count = '0;
              do_enter            = 1'b1;
              enter_ph            = PH_WASH;
            end
          end else begin
            do_stop = 1'b1;
          end
        end
        PH_WASH: begin
          if (st.sub_step == SUB_FIRST) begin
            agitating = 1'b1;
            if (agit_done) begin
              do_enter  = 1'b1;
              enter_sub = SUB_SECOND;
            end
          end else if (st.sub_step == SUB_SECOND) begin
            phase_elapsed_next = pe_inc;
            if (pause_done) begin
              do_enter = 1'b1;
              if (st.round_count >= cfg.wash_rounds_minus_one) begin
                st_next.round_count = '0;
                enter_sub           = SUB_THIRD;
              end else begin
                st_next.round_count = st.round_count + 1'b1;
              end
            end
          end else if (st.sub_step == SUB_THIRD) begin
            if (item.tank_empty) begin
              do_enter = 1'b1;
              enter_ph = PH_RINSE;
            end
          end else begin
            do_stop = 1'b1;
          end
        end
        PH_RINSE: begin
          if (st.sub_step == SUB_FIRST) begin
            if (item.tank_full) begin
              do_enter  = 1'b1;
              enter_sub = SUB_SECOND;
            end
          end else if (st.sub_step == SUB_SECOND) begin
            agitating = 1'b1;
            if (agit_done) begin
              do_enter  = 1'b1;
              enter_sub = SUB_THIRD;
            end
          end else if (st.sub_step == SUB_THIRD) begin
            if (item.tank_empty) begin
              do_enter = 1'b1;
              enter_ph = PH_SPIN;
            end
          end else begin
            do_stop = 1'b1;
          end
        end
        PH_SPIN: begin
          phase_elapsed_next = pe_inc;
          if (spin_done) do_stop = 1'b1;
        end
        PH_EMERG: begin
          if (!item.door_open) do_stop = 1'b1;
        end
        default: do_stop = 1'b1;
      endcase
    end

    // Advance agitation timers and reverse the motor
    if (agitating) begin
      phase_elapsed_next     = pe_inc;
      reverse_elapsed_next   = reverse_now ? '0 : re_inc;
      st_next.spin_direction = st.spin_direction ^ reverse_now;
    end

    if (do_stop) begin
      do_enter             = 1'b1;
      enter_ph             = PH_STOP;
      enter_sub            = SUB_FIRST;
      st_next.start_choice = CHOICE_SOAK;
      st_next.round_count  = '0;
    end

    // Enter a step: clear timers and direction
    if (do_enter) begin
      st_next.phase          = enter_ph;
      st_next.sub_step       = enter_sub;
      phase_elapsed_next     = '0;
      reverse_elapsed_next   = '0;
      st_next.spin_direction = 1'b0;
    end
  end

  // Lamps and drives from the state after the tick
  always_comb begin
    result                = '0;
    result.phase          = phase_code(st_next.phase);
    result.selected_first = st_next.start_choice;
    unique case (st_next.phase)
      PH_STOP: begin
        result.stop_lamp  = 1'b1;
        result.soak_lamp  = (st_next.start_choice == CHOICE_SOAK);
        result.wash_lamp  = (st_next.start_choice <= CHOICE_WASH);
        result.rinse_lamp = (st_next.start_choice <= CHOICE_RINSE);
        result.spin_lamp  = 1'b1;
      end
      PH_SOAK: begin
        result.soak_lamp  = 1'b1;
        result.fill_valve = (st_next.sub_step == SUB_FIRST);
        if (st_next.sub_step == SUB_SECOND) begin
          result.motor_right = !st_next.spin_direction;
          result.motor_left  = st_next.spin_direction;
        end
      end
      PH_WASH: begin
        result.wash_lamp  = 1'b1;
        result.drain_pump = (st_next.sub_step == SUB_THIRD);
        if (st_next.sub_step == SUB_FIRST) begin
          result.motor_right = !st_next.spin_direction;
          result.motor_left  = st_next.spin_direction;
        end
      end
      PH_RINSE: begin
        result.rinse_lamp = 1'b1;
        result.fill_valve = (st_next.sub_step == SUB_FIRST);
        result.drain_pump = (st_next.sub_step == SUB_THIRD);
        if (st_next.sub_step == SUB_SECOND) begin
          result.motor_right = !st_next.spin_direction;
          result.motor_left  = st_next.spin_direction;
        end
      end
      PH_SPIN: begin
        result.spin_lamp   = 1'b1;
        result.motor_right = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* src/wash_cycle_sequencer.sv */
// Wash cycle sequencer: runs soak, wash, rinse and final spin phases.
// Input channel (in_valid/in_stall/in_data): one transaction per millisecond
//   tick with the debounced select and start presses, the tank sensors and
//   the door switch.
// Output channel (out_valid/out_stall/out_data): exactly one transaction per
//   input transaction, giving the phase, chosen first phase, lamps and drives
//   after that tick.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the phase
//   lengths, wash round count and reverse period; ready is always high.
//   Write only while no transaction is in flight.
// Result: registered as the input is taken; out_valid rises in the next cycle.
// Throughput: one tick per cycle while in_stall is low; the phase logic between the state
//   registers and the result register is combinational.
// Reset (rst, synchronous): stop phase, soak chosen, timers cleared, config
//   back to its defaults, no result pending.
// Stall: while a result waits under out_stall, in_stall is raised; a result
//   taken in the same cycle frees the register for the next tick.
module wash_cycle_sequencer import wcs_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_state_t            st;
  ctl_state_t            st_next;
  logic [TIMER_BITS-1:0] phase_elapsed;
  logic [TIMER_BITS-1:0] phase_elapsed_next;
  logic [TIMER_BITS-1:0] reverse_elapsed;
  logic [TIMER_BITS-1:0] reverse_elapsed_next;
  cfg_t                  cfg;
  out_item_t             result;
  logic                  in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  wcs_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .st                   (st),
    .phase_elapsed        (phase_elapsed),
    .reverse_elapsed      (reverse_elapsed),
    .cfg                  (cfg),
    .item                 (in_data),
    .st_next              (st_next),
    .phase_elapsed_next   (phase_elapsed_next),
    .reverse_elapsed_next (reverse_elapsed_next),
    .result               (result)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.soak_spin_ms          <= SOAK_SPIN_RST;
      cfg.wash_spin_ms          <= WASH_SPIN_RST;
      cfg.wash_pause_ms         <= WASH_PAUSE_RST;
      cfg.wash_rounds_minus_one <= WASH_ROUNDS_RST;
      cfg.rinse_spin_ms         <= RINSE_SPIN_RST;
      cfg.final_spin_ms         <= FINAL_SPIN_RST;
      cfg.reverse_period_ms     <= REVERSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOAK_SPIN:   cfg.soak_spin_ms          <= cfg_data;
        CFG_WASH_SPIN:   cfg.wash_spin_ms          <= cfg_data;
        CFG_WASH_PAUSE:  cfg.wash_pause_ms         <= cfg_data;
        CFG_WASH_ROUNDS: cfg.wash_rounds_minus_one <= cfg_data[3:0];
        CFG_RINSE_SPIN:  cfg.rinse_spin_ms         <= cfg_data;
        CFG_FINAL_SPIN:  cfg.final_spin_ms         <= cfg_data;
        CFG_REVERSE:     cfg.reverse_period_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_STOP;
      st.sub_step       <= SUB_FIRST;
      st.start_choice   <= CHOICE_SOAK;
      st.spin_direction <= 1'b0;
      st.round_count    <= '0;
      st.door_prev      <= 1'b0;
      phase_elapsed     <= '0;
      reverse_elapsed   <= '0;
    end else if (in_accept) begin
      st              <= st_next;
      phase_elapsed   <= phase_elapsed_next;
      reverse_elapsed <= reverse_elapsed_next;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

endmodule

/* src/wcs_checker.sv */
`include "wash_cycle_sequencer_defines.svh"

module wcs_checker import wcs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic in_taken;
  logic out_taken;
  logic drives_off;

  assign in_taken   = in_valid && !in_stall;
  assign out_taken  = out_valid && !out_stall;
  assign drives_off = !out_data.fill_valve && !out_data.drain_pump &&
                      !out_data.motor_right && !out_data.motor_left;

  // Every accepted tick gives a result in the next cycle
  `WCS_ASSERT_NEXT(a_accept_gives_result, in_taken, out_valid)

  // No result appears without a tick behind it
  `WCS_ASSERT_NEXT(a_no_extra_result, out_taken && !in_taken, !out_valid)

  // A stalled result holds
  `WCS_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_data))

  // Emergency leaves every drive off
  `WCS_ASSERT_SAME(a_emerg_drives_off, out_valid && out_data.phase == PHC_EMERG, drives_off)

  // Motor never driven both ways
  `WCS_ASSERT_SAME(a_motor_exclusive, out_valid, !(out_data.motor_right && out_data.motor_left))

endmodule

bind wash_cycle_sequencer wcs_checker u_wcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/sv/wcs_checker.sv */
module wcs_scoreboard import wcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] TIMER_TOP = 16'hFFFF;

  // Shadow copy of the register file and the sequencer state
  cfg_t        regs;
  logic [2:0]  ph;
  logic [1:0]  sub;
  logic [1:0]  choice;
  logic [15:0] elapsed;
  logic [15:0] rev_elapsed;
  logic        dir;
  logic [3:0]  rounds;
  logic        door_was;

  // Panels still owed by the block, oldest first
  out_item_t pending_panels[$];

  function automatic logic [15:0] bump(logic [15:0] t);
    return (t == TIMER_TOP) ? t : t + 16'd1;
  endfunction

  function void enter_phase(logic [2:0] p, logic [1:0] s);
    ph = p;
    sub = s;
    elapsed = '0;
    rev_elapsed = '0;
    dir = 1'b0;
  endfunction

  function void back_to_stop();
    enter_phase(PHC_STOP, SUB_FIRST);
    choice = CHOICE_SOAK;
    rounds = '0;
  endfunction

  // One tick of agitation; true once the step length is exceeded
  function logic agitate(logic [15:0] len);
    elapsed = bump(elapsed);
    rev_elapsed = bump(rev_elapsed);
    if (rev_elapsed >= regs.reverse_period_ms) begin
      dir = ~dir;
      rev_elapsed = '0;
    end
    return elapsed > len;
  endfunction

  function void restore_defaults();
    regs.soak_spin_ms = SOAK_SPIN_RST;
    regs.wash_spin_ms = WASH_SPIN_RST;
    regs.wash_pause_ms = WASH_PAUSE_RST;
    regs.wash_rounds_minus_one = WASH_ROUNDS_RST;
    regs.rinse_spin_ms = RINSE_SPIN_RST;
    regs.final_spin_ms = FINAL_SPIN_RST;
    regs.reverse_period_ms = REVERSE_RST;
    back_to_stop();
    door_was = 1'b0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SOAK_SPIN:   regs.soak_spin_ms = val;
      CFG_WASH_SPIN:   regs.wash_spin_ms = val;
      CFG_WASH_PAUSE:  regs.wash_pause_ms = val;
      CFG_WASH_ROUNDS: regs.wash_rounds_minus_one = val[3:0];
      CFG_RINSE_SPIN:  regs.rinse_spin_ms = val;
      CFG_FINAL_SPIN:  regs.final_spin_ms = val;
      CFG_REVERSE:     regs.reverse_period_ms = val;
      default: ;
    endcase
  endfunction

  // Advance the sequencer by one tick and work out the panel it shows
  function out_item_t next_panel(in_item_t t);
    out_item_t o;
    logic      rising;
    logic      agitating;
    rising = t.door_open && !door_was;
    door_was = t.door_open;
    if (rising) begin
      enter_phase(PHC_EMERG, SUB_FIRST);
      rounds = '0;
    end else begin
      case (ph)
        PHC_STOP: begin
          if (t.start_press) begin
            rounds = '0;
            enter_phase({1'b0, choice} + 3'd1, SUB_FIRST);
          end else if (t.select_press) begin
            choice = choice + 2'd1;
          end
        end
        PHC_SOAK: begin
          if (sub == SUB_FIRST) begin
            if (t.tank_full) enter_phase(PHC_SOAK, SUB_SECOND);
          end else if (sub == SUB_SECOND) begin
            if (agitate(regs.soak_spin_ms)) begin
              rounds = '0;
              enter_phase(PHC_WASH, SUB_FIRST);
            end
          end else begin
            back_to_stop();
          end
        end
        PHC_WASH: begin
          if (sub == SUB_FIRST) begin
            if (agitate(regs.wash_spin_ms)) enter_phase(PHC_WASH, SUB_SECOND);
          end else if (sub == SUB_SECOND) begin
            elapsed = bump(elapsed);
            if (elapsed > regs.wash_pause_ms) begin
              if (rounds >= regs.wash_rounds_minus_one) begin
                rounds = '0;
                enter_phase(PHC_WASH, SUB_THIRD);
              end else begin
                rounds = rounds + 4'd1;
                enter_phase(PHC_WASH, SUB_FIRST);
              end
            end
          end else if (sub == SUB_THIRD) begin
            if (t.tank_empty) enter_phase(PHC_RINSE, SUB_FIRST);
          end else begin
            back_to_stop();
          end
        end
        PHC_RINSE: begin
          if (sub == SUB_FIRST) begin
            if (t.tank_full) enter_phase(PHC_RINSE, SUB_SECOND);
          end else if (sub == SUB_SECOND) begin
            if (agitate(regs.rinse_spin_ms)) enter_phase(PHC_RINSE, SUB_THIRD);
          end else if (sub == SUB_THIRD) begin
            if (t.tank_empty) enter_phase(PHC_SPIN, SUB_FIRST);
          end else begin
            back_to_stop();
          end
        end
        PHC_SPIN: begin
          elapsed = bump(elapsed);
          if (elapsed > regs.final_spin_ms) back_to_stop();
        end
        PHC_EMERG: begin
          if (!t.door_open) back_to_stop();
        end
        default: back_to_stop();
      endcase
    end

    // Lamps: in stop the chosen phase onward, otherwise the running phase only
    o = '0;
    o.phase = ph;
    o.selected_first = choice;
    if (ph == PHC_STOP) begin
      o.stop_lamp = 1'b1;
      o.soak_lamp = (choice == CHOICE_SOAK);
      o.wash_lamp = (choice <= CHOICE_WASH);
      o.rinse_lamp = (choice <= CHOICE_RINSE);
      o.spin_lamp = 1'b1;
    end else begin
      o.soak_lamp = (ph == PHC_SOAK);
      o.wash_lamp = (ph == PHC_WASH);
      o.rinse_lamp = (ph == PHC_RINSE);
      o.spin_lamp = (ph == PHC_SPIN);
    end

    // Drives
    o.fill_valve = (ph == PHC_SOAK || ph == PHC_RINSE) && sub == SUB_FIRST;
    o.drain_pump = (ph == PHC_WASH || ph == PHC_RINSE) && sub == SUB_THIRD;
    agitating = (ph == PHC_SOAK && sub == SUB_SECOND) ||
                (ph == PHC_WASH && sub == SUB_FIRST) ||
                (ph == PHC_RINSE && sub == SUB_SECOND);
    if (agitating) begin
      o.motor_right = !dir;
      o.motor_left = dir;
    end else if (ph == PHC_SPIN) begin
      o.motor_right = 1'b1;
    end
    return o;
  endfunction

  function void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Follow the three channels at each clock edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      restore_defaults();
      pending_panels.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (pending_panels.size() == 0) begin
          $display("%0t: no panel expected, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = pending_panels.pop_front();
          check_field("phase", 4'(want.phase), 4'(out_data.phase));
          check_field("selected_first", 4'(want.selected_first),
                      4'(out_data.selected_first));
          check_field("stop_lamp", 4'(want.stop_lamp), 4'(out_data.stop_lamp));
          check_field("soak_lamp", 4'(want.soak_lamp), 4'(out_data.soak_lamp));
          check_field("wash_lamp", 4'(want.wash_lamp), 4'(out_data.wash_lamp));
          check_field("rinse_lamp", 4'(want.rinse_lamp), 4'(out_data.rinse_lamp));
          check_field("spin_lamp", 4'(want.spin_lamp), 4'(out_data.spin_lamp));
          check_field("fill_valve", 4'(want.fill_valve), 4'(out_data.fill_valve));
          check_field("drain_pump", 4'(want.drain_pump), 4'(out_data.drain_pump));
          check_field("motor_right", 4'(want.motor_right), 4'(out_data.motor_right));
          check_field("motor_left", 4'(want.motor_left), 4'(out_data.motor_left));
        end
      end
      if (in_valid && !in_stall) pending_panels.push_back(next_panel(in_data));
      pending <= pending_panels.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
module tb import wcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int TIMER_TOP = 65535;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    pending;

  // Traffic shaping, set per phase of the run
  int   gap_pct = 20;
  int   stall_pct = 20;
  int   noise_pct = 5;
  logic hold_req = 1'b0;
  logic door_level = 1'b0;
  int   quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wash_cycle_sequencer dut (.*);
  wcs_scoreboard chk (.*);

  // Mostly short idle runs, now and then a long one
  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function in_item_t mk(logic s, logic st, logic f, logic e, logic d);
    return '{select_press: s, start_press: st, tank_full: f, tank_empty: e, door_open: d};
  endfunction

  function cfg_t settings(int soak, int wspin, int pause, int rnds, int rinse, int fin,
                          int rev);
    cfg_t s;
    s.soak_spin_ms = 16'(soak);
    s.wash_spin_ms = 16'(wspin);
    s.wash_pause_ms = 16'(pause);
    s.wash_rounds_minus_one = 4'(rnds);
    s.rinse_spin_ms = 16'(rinse);
    s.final_spin_ms = 16'(fin);
    s.reverse_period_ms = 16'(rev);
    return s;
  endfunction

  function cfg_t random_settings();
    return settings($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                    $urandom_range(0, 15), $urandom_range(0, 12), $urandom_range(0, 12),
                    $urandom_range(0, 5));
  endfunction

  // Plausible tick: rare door openings, presses and tank sensors at random;
  // a share of ticks is plain noise
  function in_item_t random_tick();
    in_item_t t;
    if ($urandom_range(0, 99) < noise_pct) begin
      t = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 3) != 0) t.door_open = door_level;
      door_level = t.door_open;
    end else begin
      if (door_level) door_level = ($urandom_range(0, 2) != 0);
      else door_level = ($urandom_range(0, 199) == 0);
      t.select_press = ($urandom_range(0, 5) == 0);
      t.start_press = ($urandom_range(0, 9) == 0);
      t.tank_full = ($urandom_range(0, 2) == 0);
      t.tank_empty = ($urandom_range(0, 2) == 0);
      t.door_open = door_level;
    end
    return t;
  endfunction

  // Offer one tick, holding it until the block takes it
  task automatic send(in_item_t item);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Leave valid high between writes; load_settings drops it at the end
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(cfg_t s);
    write_reg(CFG_SOAK_SPIN, s.soak_spin_ms);
    write_reg(CFG_WASH_SPIN, s.wash_spin_ms);
    write_reg(CFG_WASH_PAUSE, s.wash_pause_ms);
    write_reg(CFG_WASH_ROUNDS, {12'd0, s.wash_rounds_minus_one});
    write_reg(CFG_RINSE_SPIN, s.rinse_spin_ms);
    write_reg(CFG_FINAL_SPIN, s.final_spin_ms);
    write_reg(CFG_REVERSE, s.reverse_period_ms);
    cfg_valid <= 1'b0;
  endtask

  // Drain every outstanding panel, then allow for the result register
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_phase(cfg_t s, int n, int gaps, int stalls, int noise, logic hold);
    wait_idle();
    load_settings(s);
    gap_pct = gaps;
    stall_pct = stalls;
    noise_pct = noise;
    hold_req = hold;
    repeat (n) send(random_tick());
  endtask

  // Receiver: random stall runs, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up after a long stretch with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset settings
    send(mk(0, 0, 0, 0, 0));
    repeat (4) send(mk(1, 0, 0, 0, 0));
    send(mk(0, 0, 1, 1, 0));
    send(mk(1, 1, 0, 0, 0));
    send(mk(0, 0, 0, 1, 0));
    send(mk(1, 1, 1, 0, 0));
    repeat (2) send(mk(0, 0, 1, 0, 0));
    send(mk(0, 0, 0, 0, 1));
    send(mk(0, 1, 0, 0, 1));
    send(mk(0, 0, 0, 0, 0));
    repeat (3) send(mk(1, 0, 0, 0, 0));
    send(mk(0, 1, 0, 0, 0));
    repeat (2) send(mk(0, 0, 0, 0, 0));
    send(mk(1, 1, 1, 1, 1));
    send(mk(1, 1, 1, 1, 1));
    send(mk(0, 0, 0, 0, 0));

    // Random phases under several settings
    run_phase(settings(5, 4, 3, 2, 6, 5, 2), 250, 0, 20, 5, 1'b1);
    run_phase(settings(1, 1, 1, 0, 1, 1, 1), 150, 0, 0, 5, 1'b0);
    run_phase(settings(0, 0, 0, 0, 0, 0, 0), 150, 20, 50, 5, 1'b0);
    run_phase(settings($urandom_range(2, 6), $urandom_range(2, 6), $urandom_range(2, 6),
                       15, $urandom_range(2, 6), $urandom_range(2, 6), 3),
              250, 30, 30, 3, 1'b0);
    wait_idle();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    run_phase(settings(TIMER_TOP, TIMER_TOP, TIMER_TOP, 15, TIMER_TOP, TIMER_TOP,
                       TIMER_TOP), 80, 20, 20, 40, 1'b0);
    repeat (3) run_phase(random_settings(), 150, 25, 25, 8, 1'b0);

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
